@@ rtl/vms_pkg.sv @@
// ----------------------------------------------------------------------------
// vms_pkg
// Shared widths, operation codes and status codes of the value stack.
// ----------------------------------------------------------------------------
package vms_pkg;

	// Field widths of the request and response transfers
	localparam int OP_W        = 3;
	localparam int INDEX_W     = 8;
	localparam int SEC_INDEX_W = 6;
	localparam int VALUE_W     = 64;
	localparam int DEPTH_NOW_W = 7;
	localparam int STATUS_W    = 2;

	// Default configuration
	localparam int DEPTH_DEF       = 64;
	localparam int VALUE_WIDTH_DEF = 64;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
	localparam logic [OP_W-1:0] OP_POP  = 3'd1;
	localparam logic [OP_W-1:0] OP_GET  = 3'd2;
	localparam logic [OP_W-1:0] OP_SET  = 3'd3;
	localparam logic [OP_W-1:0] OP_REV  = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd3;

endpackage

@@ rtl/vms_req_if.sv @@
// ----------------------------------------------------------------------------
// vms_req_if
// Request channel: one stack operation per transfer.
// ----------------------------------------------------------------------------
interface vms_req_if
	import vms_pkg::*;
	();

	logic                          valid;
	logic                          ready;
	logic        [OP_W-1:0]        op;
	logic signed [INDEX_W-1:0]     index;
	logic        [SEC_INDEX_W-1:0] second_index;
	logic        [VALUE_W-1:0]     value;

	modport source (output valid, output op, output index, output second_index,
		output value, input ready);
	modport sink (input valid, input op, input index, input second_index,
		input value, output ready);

endinterface

@@ rtl/vms_rsp_if.sv @@
// ----------------------------------------------------------------------------
// vms_rsp_if
// Response channel: one result per stack operation.
// ----------------------------------------------------------------------------
interface vms_rsp_if
	import vms_pkg::*;
	();

	logic                   valid;
	logic                   ready;
	logic [VALUE_W-1:0]     read_value;
	logic [DEPTH_NOW_W-1:0] depth_now;
	logic [STATUS_W-1:0]    status;

	modport source (output valid, output read_value, output depth_now,
		output status, input ready);
	modport sink (input valid, input read_value, input depth_now,
		input status, output ready);

endinterface

@@ rtl/vm_value_stack.sv @@
// ----------------------------------------------------------------------------
// vm_value_stack
// Fixed-capacity interpreter value stack held in one synchronous memory.
// ----------------------------------------------------------------------------
// Each request transfer carries one operation (push, pop, get, set, reverse)
// and produces exactly one response transfer with the fetched value, the top
// count after the operation and a status. Push, set, every failing operation
// and a reverse with no pair to swap finish in the cycle the request is taken;
// pop and get finish in S_READ, once the registered read of the slot memory
// returns the word. Reverse steps through four states per swapped pair of
// slots (read lower, read upper, write upper, write lower through the single
// read and write port). A new request is taken whenever the sequencer is
// idle, even while the previous response is still waiting; a response that
// cannot leave is parked and the sequencer holds until the output register
// frees. After reset a clearing pass writes null (zero) into every slot, one
// slot per cycle, so no request is taken until the pass has finished.
// ----------------------------------------------------------------------------
module vm_value_stack
	import vms_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	vms_req_if.sink          req,
	vms_rsp_if.source        rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // slot address
	localparam int TW = $clog2(DEPTH + 1);                 // top count
	localparam int IW = ((TW > INDEX_W) ? TW : INDEX_W) + 2; // signed position
	localparam logic signed [IW-1:0] DEPTH_S = IW'(DEPTH);
	localparam logic        [TW-1:0] DEPTH_T = TW'(DEPTH);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_REV_LO,
		S_REV_HI,
		S_REV_WR_HI,
		S_REV_WR_LO,
		S_HOLD
	} state_t;

	// Slot memory: one write and one registered read per cycle
	logic [VALUE_WIDTH-1:0] mem [DEPTH];
	logic [VALUE_WIDTH-1:0] mem_rdata_s1;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [VALUE_WIDTH-1:0] mem_wdata;
	logic [AW-1:0]          mem_raddr;

	// Sequencer state
	state_t                 state_q, state_d;
	logic [TW-1:0]          top_q, top_d;
	logic [AW-1:0]          clr_q, clr_d;   // next slot of the clearing pass
	logic [AW-1:0]          lo_q, lo_d;
	logic [AW-1:0]          hi_q, hi_d;
	logic [VALUE_WIDTH-1:0] tmp_q, tmp_d;
	logic                   rd_ok_q, rd_ok_d;

	// Output register and parked response
	logic                   rsp_valid_q;
	logic [VALUE_W-1:0]     rsp_value_q;
	logic [DEPTH_NOW_W-1:0] rsp_depth_q;
	logic [STATUS_W-1:0]    rsp_status_q;
	logic [VALUE_W-1:0]     pend_value_q;
	logic [DEPTH_NOW_W-1:0] pend_depth_q;
	logic [STATUS_W-1:0]    pend_status_q;

	// Result of the current operation, when it finishes this cycle
	logic                   fin_valid;
	logic [VALUE_W-1:0]     fin_value;
	logic [DEPTH_NOW_W-1:0] fin_depth;
	logic [STATUS_W-1:0]    fin_status;
	logic                   load_out;
	logic                   load_pend;
	logic                   out_free;

	// Index decoding
	logic                   accept;
	logic signed [IW-1:0]   idx_ext;
	logic signed [IW-1:0]   top_ext;
	logic signed [IW-1:0]   sec_ext;
	logic signed [IW-1:0]   pos;
	logic signed [IW-1:0]   pos_m1;
	logic                   pos_ok;
	logic                   rev_ok;
	logic [VALUE_WIDTH-1:0] fetched;
	logic [VALUE_WIDTH-1:0] push_val;
	logic [AW:0]            lo_next2;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_free = !rsp_valid_q || rsp.ready;

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rsp_value_q;
	assign rsp.depth_now  = rsp_depth_q;
	assign rsp.status     = rsp_status_q;

	// Resolve a signed stack index into a one-based position; negative counts
	// back from the top
	assign idx_ext = IW'(req.index);
	assign top_ext = $signed(IW'(top_q));
	assign sec_ext = $signed(IW'(req.second_index));
	assign pos     = req.index[INDEX_W-1] ? (idx_ext + top_ext + IW'(1)) : idx_ext;
	assign pos_m1  = pos - IW'(1);
	assign pos_ok  = (pos > IW'(0)) && (pos <= top_ext);
	assign rev_ok  = !req.index[INDEX_W-1] && (idx_ext < DEPTH_S) && (sec_ext < DEPTH_S);

	assign fetched  = mem_rdata_s1;
	assign push_val = req.value[VALUE_WIDTH-1:0];
	assign lo_next2 = {1'b0, lo_q} + (AW+1)'(2);

	always_comb begin
		state_d    = state_q;
		top_d      = top_q;
		clr_d      = clr_q;
		lo_d       = lo_q;
		hi_d       = hi_q;
		tmp_d      = tmp_q;
		rd_ok_d    = rd_ok_q;
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = '0;
		mem_raddr  = lo_q;
		fin_valid  = 1'b0;
		fin_value  = '0;
		fin_depth  = DEPTH_NOW_W'(top_q);
		fin_status = ST_OK;
		unique case (state_q)
			S_CLEAR: begin
				// write null into one slot per cycle until the last one
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				clr_d     = clr_q + AW'(1);
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					case (req.op)
						OP_PUSH: begin
							fin_valid = 1'b1;
							if (top_q >= DEPTH_T) begin
								fin_status = ST_OVERFLOW;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = AW'(top_q);
								mem_wdata = push_val;
								top_d     = top_q + TW'(1);
								fin_depth = DEPTH_NOW_W'(top_d);
							end
						end
						OP_POP: begin
							if (top_q == '0) begin
								fin_valid  = 1'b1;
								fin_status = ST_UNDERFLOW;
							end else begin
								// read the old word and clear the slot at the same edge
								top_d     = top_q - TW'(1);
								mem_raddr = AW'(top_d);
								mem_we    = 1'b1;
								mem_waddr = AW'(top_d);
								mem_wdata = '0;
								rd_ok_d   = 1'b1;
								state_d   = S_READ;
							end
						end
						OP_GET: begin
							mem_raddr = pos_m1[AW-1:0];
							rd_ok_d   = pos_ok;
							state_d   = S_READ;
						end
						OP_SET: begin
							fin_valid = 1'b1;
							if (pos_ok) begin
								mem_we    = 1'b1;
								mem_waddr = pos_m1[AW-1:0];
								mem_wdata = push_val;
							end else begin
								fin_status = ST_INVALID;
							end
						end
						OP_REV: begin
							if (!rev_ok) begin
								fin_valid  = 1'b1;
								fin_status = ST_INVALID;
							end else if (idx_ext < sec_ext) begin
								lo_d    = idx_ext[AW-1:0];
								hi_d    = sec_ext[AW-1:0];
								state_d = S_REV_LO;
							end else begin
								fin_valid = 1'b1;
							end
						end
						default: begin
							fin_valid  = 1'b1;
							fin_status = ST_INVALID;
						end
					endcase
				end
			end
			S_READ: begin
				fin_valid = 1'b1;
				fin_value = rd_ok_q ? VALUE_W'(fetched) : '0;
			end
			S_REV_LO: begin
				mem_raddr = lo_q;
				state_d   = S_REV_HI;
			end
			S_REV_HI: begin
				tmp_d     = fetched;          // lower word
				mem_raddr = hi_q;
				state_d   = S_REV_WR_HI;
			end
			S_REV_WR_HI: begin
				mem_we    = 1'b1;
				mem_waddr = hi_q;
				mem_wdata = tmp_q;
				tmp_d     = fetched;          // upper word
				state_d   = S_REV_WR_LO;
			end
			S_REV_WR_LO: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q;
				mem_wdata = tmp_q;
				lo_d      = lo_q + AW'(1);
				hi_d      = hi_q - AW'(1);
				if (lo_next2 < {1'b0, hi_q}) begin
					state_d = S_REV_LO;
				end else begin
					fin_valid = 1'b1;
				end
			end
			S_HOLD: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Retire a finished operation: straight to the output register, or park
		load_out  = 1'b0;
		load_pend = 1'b0;
		if (fin_valid) begin
			if (out_free) begin
				load_out = 1'b1;
				state_d  = S_IDLE;
			end else begin
				load_pend = 1'b1;
				state_d   = S_HOLD;
			end
		end
	end

	// Sequencer, clearing pass and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			top_q       <= '0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			clr_q   <= clr_d;
			if (load_out) begin
				rsp_valid_q  <= 1'b1;
				rsp_value_q  <= fin_value;
				rsp_depth_q  <= fin_depth;
				rsp_status_q <= fin_status;
			end else if (state_q == S_HOLD && out_free) begin
				rsp_valid_q  <= 1'b1;
				rsp_value_q  <= pend_value_q;
				rsp_depth_q  <= pend_depth_q;
				rsp_status_q <= pend_status_q;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (load_pend) begin
				pend_value_q  <= fin_value;
				pend_depth_q  <= fin_depth;
				pend_status_q <= fin_status;
			end
			lo_q    <= lo_d;
			hi_q    <= hi_d;
			tmp_q   <= tmp_d;
			rd_ok_q <= rd_ok_d;
		end
	end

	// Slot memory: read returns the word held before a same-edge write
	always_ff @(posedge clk) begin
		mem_rdata_s1 <= mem[mem_raddr];
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

endmodule

@@ bench/vm_value_stack_tb.sv @@
// ----------------------------------------------------------------------------
// vm_value_stack_tb
// Self-checking bench for the interpreter value stack.
// ----------------------------------------------------------------------------
// Drive stack operations over the request channel and hold a private model
// of the slot store and top count. Predict one response for every request
// transfer and compare every response transfer with the oldest prediction.
// Start with a short directed run over the corner cases. Follow it with
// random fill, drain, reverse and mixed bursts. Both channels idle and stall
// at random, apart from one long calm stretch.
// ----------------------------------------------------------------------------

// Predicted content of one response transfer
typedef struct packed {
	logic [vms_pkg::VALUE_W-1:0]     read_value;
	logic [vms_pkg::DEPTH_NOW_W-1:0] depth_now;
	logic [vms_pkg::STATUS_W-1:0]    status;
} stack_result_t;

// Stack model and queue of responses still owed by the block
class stack_scoreboard;
	logic [vms_pkg::VALUE_W-1:0] held_slots [vms_pkg::DEPTH_DEF];
	int                          top_count;
	stack_result_t               awaited [$];
	int                          errors;

	function new();
		foreach (held_slots[i])
			held_slots[i] = '0;
		top_count = 0;
		errors    = 0;
	endfunction

	function int outstanding();
		return awaited.size();
	endfunction

	// Apply one accepted request to the model and queue its response
	function void note_request(logic [vms_pkg::OP_W-1:0] op,
		logic signed [vms_pkg::INDEX_W-1:0] idx,
		logic [vms_pkg::SEC_INDEX_W-1:0] upper, logic [vms_pkg::VALUE_W-1:0] val);
		stack_result_t               res;
		int                          pos;
		int                          lo;
		int                          hi;
		logic [vms_pkg::VALUE_W-1:0] swap;
		res.read_value = '0;
		res.status     = vms_pkg::ST_OK;
		pos = (idx >= 0) ? int'(idx) : int'(idx) + top_count + 1;
		case (op)
			vms_pkg::OP_PUSH: begin
				if (top_count >= vms_pkg::DEPTH_DEF) begin
					res.status = vms_pkg::ST_OVERFLOW;
				end else begin
					held_slots[top_count] = val;
					top_count++;
				end
			end
			vms_pkg::OP_POP: begin
				if (top_count == 0) begin
					res.status = vms_pkg::ST_UNDERFLOW;
				end else begin
					top_count--;
					res.read_value = held_slots[top_count];
					held_slots[top_count] = '0;
				end
			end
			vms_pkg::OP_GET: begin
				if (pos > 0 && pos <= top_count)
					res.read_value = held_slots[pos-1];
			end
			vms_pkg::OP_SET: begin
				if (pos > 0 && pos <= top_count)
					held_slots[pos-1] = val;
				else
					res.status = vms_pkg::ST_INVALID;
			end
			vms_pkg::OP_REV: begin
				lo = int'(idx);
				hi = int'(upper);
				if (lo < 0 || lo >= vms_pkg::DEPTH_DEF || hi >= vms_pkg::DEPTH_DEF) begin
					res.status = vms_pkg::ST_INVALID;
				end else begin
					while (lo < hi) begin
						swap           = held_slots[hi];
						held_slots[hi] = held_slots[lo];
						held_slots[lo] = swap;
						lo++;
						hi--;
					end
				end
			end
			default: res.status = vms_pkg::ST_INVALID;
		endcase
		res.depth_now = vms_pkg::DEPTH_NOW_W'(top_count);
		awaited = {awaited, res};
	endfunction

	// Compare one accepted response with the oldest prediction
	function void check_response(logic [vms_pkg::VALUE_W-1:0] read_value,
		logic [vms_pkg::DEPTH_NOW_W-1:0] depth_now, logic [vms_pkg::STATUS_W-1:0] status);
		stack_result_t want;
		if (awaited.size() == 0) begin
			$display("%0t: response with none outstanding: read_value %h depth_now %0d status %0d",
				$time, read_value, depth_now, status);
			errors++;
			return;
		end
		want = awaited.pop_front();
		if (read_value !== want.read_value) begin
			$display("%0t: read_value expected %h actual %h", $time, want.read_value, read_value);
			errors++;
		end
		if (depth_now !== want.depth_now) begin
			$display("%0t: depth_now expected %0d actual %0d", $time, want.depth_now, depth_now);
			errors++;
		end
		if (status !== want.status) begin
			$display("%0t: status expected %0d actual %0d", $time, want.status, status);
			errors++;
		end
	endfunction
endclass

module vm_value_stack_tb;
	import vms_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int RANDOM_ITEMS = 1600;
	localparam int MAX_CYCLES   = 1_500_000;
	// First of the op codes that the block does not define
	localparam logic [OP_W-1:0] OP_UNDEF_FIRST = OP_REV + 1'b1;
	localparam int              OP_LAST        = (1 << OP_W) - 1;

	logic clk;
	logic arst_n;

	vms_req_if req_ch ();
	vms_rsp_if rsp_ch ();

	stack_scoreboard sb;

	// Depth as the stimulus side sees it, used to aim indices and size fill and drain runs
	int gen_depth;
	int sent;
	// High during the long stretch in which neither side idles
	bit calm;

	vm_value_stack u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Observe both channels at every rising edge. Note the request before
	// checking the response: a response never belongs to a request taken at
	// the same edge, so the order only keeps the queue well defined.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.op, req_ch.index, req_ch.second_index, req_ch.value);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response(rsp_ch.read_value, rsp_ch.depth_now, rsp_ch.status);
		end
	end

	// Response side: stall in about a third of the cycles, never while calm
	initial begin
		@(posedge clk iff arst_n);
		forever begin
			rsp_ch.ready <= calm || ($urandom_range(99) >= 35);
			@(posedge clk);
		end
	end

	// Hard stop in case the block hangs
	initial begin
		#(CLK_PERIOD * MAX_CYCLES);
		$display("FAILURE");
		$finish;
	end

	function automatic logic [VALUE_W-1:0] rand_value();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Mostly an index that hits a live slot, in either counting direction;
	// otherwise anything from -64 to 64, bad positions included
	function automatic int rand_stack_index();
		int pos;
		if (gen_depth > 0 && $urandom_range(99) < 80) begin
			pos = $urandom_range(gen_depth, 1);
			return $urandom_range(1) ? pos : pos - gen_depth - 1;
		end
		return int'($urandom_range(128)) - 64;
	endfunction

	// Present one operation and hold it until the block takes the transfer.
	// Leave valid high afterwards so back-to-back transfers need no toggle.
	task automatic send_op(input logic [OP_W-1:0] op, input int idx, input int upper,
		input logic [VALUE_W-1:0] val);
		while (!calm && $urandom_range(99) < 35) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.op           <= op;
		req_ch.index        <= INDEX_W'(idx);
		req_ch.second_index <= SEC_INDEX_W'(upper);
		req_ch.value        <= val;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (op == OP_PUSH && gen_depth < DEPTH_DEF)
			gen_depth++;
		if (op == OP_POP && gen_depth > 0)
			gen_depth--;
		sent++;
	endtask

	// Drop valid and hold until every owed response has come back
	task automatic drain_responses();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	// One operation of the mixed traffic, weighted towards legal indices
	task automatic send_mixed_op();
		int pick;
		pick = $urandom_range(99);
		if (pick < 30)
			send_op(OP_PUSH, 0, 0, rand_value());
		else if (pick < 50)
			send_op(OP_POP, rand_stack_index(), $urandom_range(63), rand_value());
		else if (pick < 68)
			send_op(OP_GET, rand_stack_index(), $urandom_range(63), rand_value());
		else if (pick < 84)
			send_op(OP_SET, rand_stack_index(), $urandom_range(63), rand_value());
		else if (pick < 96)
			send_op(OP_REV, ($urandom_range(99) < 85) ? int'($urandom_range(DEPTH_DEF - 1))
				: int'($urandom_range(128)) - 64, $urandom_range(63), rand_value());
		else
			send_op(OP_W'($urandom_range(OP_LAST, OP_UNDEF_FIRST)), rand_stack_index(),
				$urandom_range(63), rand_value());
	endtask

	initial begin
		int  last_sent;
		bit  paused;
		int  span;
		clk                 = 1'b0;
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.op           = OP_PUSH;
		req_ch.index        = '0;
		req_ch.second_index = '0;
		req_ch.value        = '0;
		rsp_ch.ready        = 1'b0;
		sb        = new();
		gen_depth = 0;
		sent      = 0;
		calm      = 1'b0;
		paused    = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-stack errors and reads first
		send_op(OP_POP, 0, 0, '0);                 // underflow
		send_op(OP_GET, 1, 0, '0);                 // bad index reads null, ok
		send_op(OP_SET, -1, 0, '1);                // bad set index
		send_op(OP_REV, 0, 63, '0);                // full range over null slots
		send_op(OP_REV, -1, 5, '0);                // negative lower slot
		send_op(OP_REV, 64, 0, '0);                // lower slot past capacity
		for (int c = int'(OP_UNDEF_FIRST); c <= OP_LAST; c++)
			send_op(OP_W'(c), 0, 0, '1);           // undefined op codes
		// Then a few values and every index form
		send_op(OP_PUSH, 0, 0, '0);                // null value
		send_op(OP_PUSH, 0, 0, '1);
		send_op(OP_PUSH, 0, 0, rand_value());
		send_op(OP_GET, 1, 0, '0);
		send_op(OP_GET, -1, 0, '0);
		send_op(OP_GET, 0, 0, '0);                 // position zero is never valid
		send_op(OP_GET, -64, 0, '0);               // counts back past the bottom
		send_op(OP_GET, 64, 0, '0);                // above the top
		send_op(OP_SET, 2, 0, rand_value());
		send_op(OP_SET, 0, 0, rand_value());       // bad set index
		send_op(OP_REV, 2, 0, '0);                 // lower above upper: no swap
		send_op(OP_REV, 1, 1, '0);                 // lower equals upper
		send_op(OP_REV, 0, 63, '0);                // swaps run above the top
		send_op(OP_POP, -1, 0, '0);
		send_op(OP_POP, 0, 0, '0);

		// Let everything settle before the random traffic
		drain_responses();

		last_sent = sent + RANDOM_ITEMS;
		while (sent < last_sent) begin
			// Keep a long calm stretch in the middle of the run
			calm = (sent >= last_sent - 1000) && (sent < last_sent - 700);
			if (!paused && sent >= last_sent - 400) begin
				paused = 1'b1;
				drain_responses();
			end
			case ($urandom_range(9))
				0, 1: begin
					// Fill to capacity and knock on the lid a few times
					span = DEPTH_DEF - gen_depth + $urandom_range(3);
					repeat (span) send_op(OP_PUSH, 0, 0, rand_value());
				end
				2: begin
					// Drain to empty and go up to two past the bottom
					span = gen_depth + $urandom_range(2);
					repeat (span) send_op(OP_POP, 0, 0, '0);
				end
				3: begin
					repeat ($urandom_range(6, 2))
						send_op(OP_REV, $urandom_range(DEPTH_DEF - 1), $urandom_range(63), '0);
				end
				default: begin
					repeat ($urandom_range(40, 10)) send_mixed_op();
				end
			endcase
		end
		calm = 1'b0;

		drain_responses();
		// Allow for any stray response the block might still emit
		repeat (20) @(posedge clk);

		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
